@@ src/aclr_pkg.sv @@
// Package for the alarm clock LED ramp: request/response types, codes and constants.
package aclr_pkg;

   // Request command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_SET_TIME = 2'd1;
   localparam logic [1:0] CMD_LOAD_DELAY = 2'd2;

   // Ramp phase codes
   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_RISE = 2'd1;
   localparam logic [1:0] PHASE_SET = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SUNRISE_HOUR = 2'd0;
   localparam logic [1:0] CSR_SUNRISE_MINUTE = 2'd1;
   localparam logic [1:0] CSR_SUNSET_HOUR = 2'd2;
   localparam logic [1:0] CSR_SUNSET_MINUTE = 2'd3;

   // Reset values of the alarm registers
   localparam logic [4:0] SUNRISE_HOUR_RST = 5'd14;
   localparam logic [5:0] SUNRISE_MINUTE_RST = 6'd26;
   localparam logic [4:0] SUNSET_HOUR_RST = 5'd14;
   localparam logic [5:0] SUNSET_MINUTE_RST = 6'd36;

   // Ramp and clock limits
   localparam logic [7:0] RISE_START = 8'd254;
   localparam logic [7:0] SET_END = 8'd255;
   localparam logic [1:0] HOLD_TICKS = 2'd2;
   localparam logic [5:0] LAST_SECOND = 6'd59;
   localparam logic [5:0] LAST_MINUTE = 6'd59;
   localparam logic [4:0] LAST_HOUR = 5'd23;

   localparam int DELAY_W = 10;

   typedef struct packed {
      logic [1:0] command;
      logic [4:0] set_hours;
      logic [5:0] set_minutes;
      logic [5:0] set_seconds;
      logic [7:0] table_index;
      logic [9:0] table_delay;
   } req_type;

   typedef struct packed {
      logic [7:0] duty_value;
      logic       pwm_running;
      logic [1:0] ramp_mode;
      logic [4:0] clock_hours;
      logic [5:0] clock_minutes;
      logic [5:0] clock_seconds;
   } rsp_type;

endpackage

@@ src/aclr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read (read-first).
module aclr_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ src/alarm_clock_led_ramp.sv @@
// Top level of the alarm clock LED ramp: clock, alarm match, ramp sequencer and delay table.
//
// Each request (one-second tick, clock set or delay-table load) gives exactly one
// response carrying the PWM compare value, PWM run flag, ramp mode and clock time
// after that request. One request is taken per clock cycle while the response
// register is free or being taken; a request passes an input register and then the
// response register, so full throughput holds whenever the response is not stalled.
// The dwell table sits in a RAM whose registered read port always points at the
// next ramp level, so its dwell time is ready when the next tick arrives; a load to
// that same level is forwarded. Table entries must be loaded before a ramp reaches them.
module alarm_clock_led_ramp #(
   parameter int TABLE_DEPTH = 255
) (
   input  logic             clock,
   input  logic             reset,
   // Request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  aclr_pkg::req_type req_data,
   // Response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aclr_pkg::rsp_type rsp_data,
   // Configuration writes
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [7:0] DEPTH_LV = 8'(TABLE_DEPTH);

   // Alarm registers
   logic [4:0] rise_hour_ff, set_hour_ff;
   logic [5:0] rise_min_ff, set_min_ff;

   // Input register
   aclr_pkg::req_type in_ff;
   logic              in_vld_ff;

   // Clock and ramp state
   logic [4:0] hours_ff, hours_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] level_ff, level_in;
   logic       pwm_ff, pwm_in;
   logic [9:0] dwell_ff, dwell_in;
   logic [1:0] hold_ff, hold_in;

   // Response register
   aclr_pkg::rsp_type rsp_ff;
   logic              rsp_vld_ff, rsp_vld_in;

   // Delay table access
   logic              tbl_wr_en;
   logic [ADDR_W-1:0] tbl_wr_addr, tbl_rd_addr;
   logic [9:0]        tbl_rd_data;
   logic              lvl_ok_ff;
   logic              byp_ff;
   logic [9:0]        byp_data_ff;
   logic [9:0]        dwell_raw, dwell_eff;
   logic [10:0]       dwell_next;
   logic              dwell_done;
   logic [1:0]        hold_inc;
   logic              fire;

   // Handshake: stage two fires when the response register is free or being taken
   assign fire = in_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | fire;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_ff;
   assign rsp_vld_in = fire | (rsp_vld_ff & ~rsp_ready);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_hour_ff <= aclr_pkg::SUNRISE_HOUR_RST;
         rise_min_ff <= aclr_pkg::SUNRISE_MINUTE_RST;
         set_hour_ff <= aclr_pkg::SUNSET_HOUR_RST;
         set_min_ff <= aclr_pkg::SUNSET_MINUTE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            aclr_pkg::CSR_SUNRISE_HOUR: rise_hour_ff <= csr_wdata[4:0];
            aclr_pkg::CSR_SUNRISE_MINUTE: rise_min_ff <= csr_wdata;
            aclr_pkg::CSR_SUNSET_HOUR: set_hour_ff <= csr_wdata[4:0];
            aclr_pkg::CSR_SUNSET_MINUTE: set_min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         in_ff <= req_data;
      end
   end

   // Dwell of the current level: out-of-depth levels and zero entries count as one tick
   assign dwell_raw = byp_ff ? byp_data_ff : tbl_rd_data;
   assign dwell_eff = (lvl_ok_ff && dwell_raw != 10'd0) ? dwell_raw : 10'd1;
   assign dwell_next = {1'b0, dwell_ff} + 11'd1;
   assign dwell_done = dwell_next >= {1'b0, dwell_eff};
   assign hold_inc = hold_ff + 2'd1;

   // Next state for one request
   always_comb begin
      hours_in = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      phase_in = phase_ff;
      level_in = level_ff;
      pwm_in = pwm_ff;
      dwell_in = dwell_ff;
      hold_in = hold_ff;
      tbl_wr_en = 1'b0;
      if (fire) begin
         case (in_ff.command)
            aclr_pkg::CMD_TICK: begin
               // Clock advance with carries
               if (seconds_ff >= aclr_pkg::LAST_SECOND) begin
                  seconds_in = 6'd0;
                  if (minutes_ff >= aclr_pkg::LAST_MINUTE) begin
                     minutes_in = 6'd0;
                     hours_in = (hours_ff >= aclr_pkg::LAST_HOUR) ? 5'd0 : hours_ff + 5'd1;
                  end else begin
                     minutes_in = minutes_ff + 6'd1;
                  end
               end else begin
                  seconds_in = seconds_ff + 6'd1;
               end
               // Ramp step, or alarm match when idle
               case (phase_ff)
                  aclr_pkg::PHASE_RISE: begin
                     if (level_ff == 8'd0) begin
                        hold_in = hold_inc;
                        if (hold_inc >= aclr_pkg::HOLD_TICKS) begin
                           pwm_in = 1'b0;
                           phase_in = aclr_pkg::PHASE_IDLE;
                           hold_in = 2'd0;
                        end
                     end else if (dwell_done) begin
                        dwell_in = 10'd0;
                        level_in = level_ff - 8'd1;
                     end else begin
                        dwell_in = dwell_next[9:0];
                     end
                  end
                  aclr_pkg::PHASE_SET: begin
                     if (dwell_done) begin
                        dwell_in = 10'd0;
                        level_in = level_ff + 8'd1;
                        if (level_in >= aclr_pkg::SET_END) begin
                           pwm_in = 1'b0;
                           phase_in = aclr_pkg::PHASE_IDLE;
                        end
                     end else begin
                        dwell_in = dwell_next[9:0];
                     end
                  end
                  aclr_pkg::PHASE_IDLE: begin
                     if (hours_in == rise_hour_ff && minutes_in == rise_min_ff) begin
                        phase_in = aclr_pkg::PHASE_RISE;
                        level_in = aclr_pkg::RISE_START;
                        pwm_in = 1'b1;
                        dwell_in = 10'd0;
                        hold_in = 2'd0;
                     end else if (hours_in == set_hour_ff && minutes_in == set_min_ff) begin
                        phase_in = aclr_pkg::PHASE_SET;
                        level_in = 8'd0;
                        pwm_in = 1'b1;
                        dwell_in = 10'd0;
                        hold_in = 2'd0;
                     end
                  end
                  default: ;
               endcase
            end
            aclr_pkg::CMD_SET_TIME: begin
               hours_in = in_ff.set_hours;
               minutes_in = in_ff.set_minutes;
               seconds_in = in_ff.set_seconds;
            end
            aclr_pkg::CMD_LOAD_DELAY: begin
               tbl_wr_en = in_ff.table_index < DEPTH_LV;
            end
            default: ;
         endcase
      end
   end

   // Table addressing: the read port follows the level about to be current
   assign tbl_wr_addr = in_ff.table_index[ADDR_W-1:0];
   assign tbl_rd_addr = reset ? '0 : level_in[ADDR_W-1:0];

   aclr_ram #(
      .WIDTH(aclr_pkg::DELAY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_delay_ram (
      .clock(clock),
      .wr_en(tbl_wr_en),
      .wr_addr(tbl_wr_addr),
      .wr_data(in_ff.table_delay),
      .rd_addr(tbl_rd_addr),
      .rd_data(tbl_rd_data)
   );

   // Forward a load that hits the level being read this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
         lvl_ok_ff <= 1'b1;
      end else begin
         byp_ff <= tbl_wr_en && (in_ff.table_index == level_in);
         lvl_ok_ff <= level_in < DEPTH_LV;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= in_ff.table_delay;
   end

   // Clock and ramp state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff <= 5'd0;
         minutes_ff <= 6'd0;
         seconds_ff <= 6'd0;
         phase_ff <= aclr_pkg::PHASE_IDLE;
         level_ff <= 8'd0;
         pwm_ff <= 1'b0;
         dwell_ff <= 10'd0;
         hold_ff <= 2'd0;
         rsp_vld_ff <= 1'b0;
      end else begin
         hours_ff <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         phase_ff <= phase_in;
         level_ff <= level_in;
         pwm_ff <= pwm_in;
         dwell_ff <= dwell_in;
         hold_ff <= hold_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff.duty_value <= level_in;
         rsp_ff.pwm_running <= pwm_in;
         rsp_ff.ramp_mode <= phase_in;
         rsp_ff.clock_hours <= hours_in;
         rsp_ff.clock_minutes <= minutes_in;
         rsp_ff.clock_seconds <= seconds_in;
      end
   end

endmodule

@@ sim/tb_alarm_clock_led_ramp.sv @@
// Self-checking testbench for the alarm clock LED ramp: directed table, then alarm-driven random runs.
`timescale 1ns / 1ps

module tb_alarm_clock_led_ramp;

   localparam int TABLE_DEPTH = 255;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_QUOTA = 125;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   aclr_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   aclr_pkg::rsp_type rsp_data;
   logic    csr_write_en;
   logic [1:0] csr_index;
   logic [5:0] csr_wdata;

   // Predicted dimmer state
   logic [4:0] tod_h;
   logic [5:0] tod_m, tod_s;
   logic [1:0] ramp_ph;
   logic [7:0] duty;
   logic       pwm_on;
   logic [9:0] dwell_ct;
   logic [1:0] hold_ct;
   logic [9:0] dwell_tab [0:TABLE_DEPTH-1];
   logic [4:0] alm_rise_h, alm_set_h;
   logic [5:0] alm_rise_m, alm_set_m;

   aclr_pkg::rsp_type status_q [$];
   int      error_count;
   int      cycle_count;
   int      rsp_stall_left;
   bit      no_idle;

   // Directed requests: cmd, hours, minutes, seconds, index, delay, typed flag,
   // then the typed response: duty, pwm, mode, hours, minutes, seconds
   int dir_tab [0:22][0:12] = '{
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE,  0,  0,  1},
      '{CMD_UNUSED,               31, 63, 63, 255, 1023, 1, 0, 0, aclr_pkg::PHASE_IDLE,  0,  0,  1},
      '{aclr_pkg::CMD_LOAD_DELAY,  0,  0,  0, 255, 1023, 1, 0, 0, aclr_pkg::PHASE_IDLE,  0,  0,  1},
      '{aclr_pkg::CMD_LOAD_DELAY, 31, 63, 63, 254,    2, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_LOAD_DELAY,  0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_SET_TIME,   23, 59, 59,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE, 23, 59, 59},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE,  0,  0,  0},
      '{aclr_pkg::CMD_SET_TIME,   31, 63, 63,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE, 31, 63, 63},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE,  0,  0,  0},
      '{aclr_pkg::CMD_SET_TIME,   10, 58, 59,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_SET_TIME,    0,  0,  0,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE,  0,  0,  0},
      '{aclr_pkg::CMD_SET_TIME,   14, 25, 59,   0,    0, 1, 0, 0, aclr_pkg::PHASE_IDLE, 14, 25, 59},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 1,
        aclr_pkg::RISE_START, 1, aclr_pkg::PHASE_RISE, 14, 26, 0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_SET_TIME,   14, 35, 58,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_LOAD_DELAY,  0,  0,  0, 253,    5, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{CMD_UNUSED,                0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0},
      '{aclr_pkg::CMD_TICK,        0,  0,  0,   0,    0, 0, 0, 0, 0,  0,  0,  0}
   };

   alarm_clock_led_ramp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Clock
   always #5 clock = ~clock;

   // Idle or stall length for one request or response
   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 12));
   endfunction

   // Dwell seconds of a level; zero and levels past the table act as one tick
   function automatic logic [9:0] dwell_need(input logic [7:0] lv);
      logic [9:0] d;
      d = (lv < TABLE_DEPTH) ? dwell_tab[lv] : 10'd0;
      return (d == 10'd0) ? 10'd1 : d;
   endfunction

   function automatic bit is_ignored(input aclr_pkg::req_type r);
      return r.command == CMD_UNUSED ||
             (r.command == aclr_pkg::CMD_LOAD_DELAY && r.table_index >= TABLE_DEPTH);
   endfunction

   function automatic aclr_pkg::req_type rand_fields();
      aclr_pkg::req_type r;
      r.command = 2'($urandom_range(0, 3));
      r.set_hours = 5'($urandom_range(0, 31));
      r.set_minutes = 6'($urandom_range(0, 63));
      r.set_seconds = 6'($urandom_range(0, 63));
      r.table_index = 8'($urandom_range(0, 255));
      r.table_delay = 10'($urandom_range(0, 1023));
      return r;
   endfunction

   // Any command; loads mostly short dwells, clock sets mostly in range
   function automatic aclr_pkg::req_type noise_req();
      aclr_pkg::req_type r;
      r = rand_fields();
      if (r.command == aclr_pkg::CMD_LOAD_DELAY && r.table_index < TABLE_DEPTH &&
          $urandom_range(0, 31) != 0) begin
         r.table_delay = 10'($urandom_range(0, 3));
      end
      if (r.command == aclr_pkg::CMD_SET_TIME && $urandom_range(0, 3) != 0) begin
         r.set_hours = 5'($urandom_range(0, 23));
         r.set_minutes = 6'($urandom_range(0, 59));
         r.set_seconds = 6'($urandom_range(0, 59));
      end
      return r;
   endfunction

   // Dimmer predictor: applies one request, gives the status it should produce
   task automatic advance_dimmer(input aclr_pkg::req_type r, output aclr_pkg::rsp_type o);
      logic       was_running;
      logic [9:0] need;
      case (r.command)
         aclr_pkg::CMD_TICK: begin
            was_running = (ramp_ph != aclr_pkg::PHASE_IDLE);
            // clock first; anything at or past the last value wraps and carries
            if (tod_s >= aclr_pkg::LAST_SECOND) begin
               tod_s = '0;
               if (tod_m >= aclr_pkg::LAST_MINUTE) begin
                  tod_m = '0;
                  if (tod_h >= aclr_pkg::LAST_HOUR) tod_h = '0;
                  else tod_h++;
               end else begin
                  tod_m++;
               end
            end else begin
               tod_s++;
            end
            if (was_running) begin
               need = dwell_need(duty);
               if (ramp_ph == aclr_pkg::PHASE_RISE) begin
                  if (duty == 8'd0) begin
                     // bottom reached: hold a couple of ticks then stop
                     hold_ct = hold_ct + 2'd1;
                     if (hold_ct >= aclr_pkg::HOLD_TICKS) begin
                        pwm_on = 1'b0;
                        ramp_ph = aclr_pkg::PHASE_IDLE;
                        hold_ct = '0;
                     end
                  end else if ({1'b0, dwell_ct} + 11'd1 >= {1'b0, need}) begin
                     dwell_ct = '0;
                     duty--;
                  end else begin
                     dwell_ct++;
                  end
               end else if (ramp_ph == aclr_pkg::PHASE_SET) begin
                  if ({1'b0, dwell_ct} + 11'd1 >= {1'b0, need}) begin
                     dwell_ct = '0;
                     duty++;
                     if (duty >= aclr_pkg::SET_END) begin
                        pwm_on = 1'b0;
                        ramp_ph = aclr_pkg::PHASE_IDLE;
                     end
                  end else begin
                     dwell_ct++;
                  end
               end
            end else if (tod_h == alm_rise_h && tod_m == alm_rise_m) begin
               // sunrise takes priority over sunset
               ramp_ph = aclr_pkg::PHASE_RISE;
               duty = aclr_pkg::RISE_START;
               pwm_on = 1'b1;
               dwell_ct = '0;
               hold_ct = '0;
            end else if (tod_h == alm_set_h && tod_m == alm_set_m) begin
               ramp_ph = aclr_pkg::PHASE_SET;
               duty = '0;
               pwm_on = 1'b1;
               dwell_ct = '0;
               hold_ct = '0;
            end
         end
         aclr_pkg::CMD_SET_TIME: begin
            tod_h = r.set_hours;
            tod_m = r.set_minutes;
            tod_s = r.set_seconds;
         end
         aclr_pkg::CMD_LOAD_DELAY: begin
            if (r.table_index < TABLE_DEPTH) dwell_tab[r.table_index] = r.table_delay;
         end
         default: ;
      endcase
      o.duty_value = duty;
      o.pwm_running = pwm_on;
      o.ramp_mode = ramp_ph;
      o.clock_hours = tod_h;
      o.clock_minutes = tod_m;
      o.clock_seconds = tod_s;
   endtask

   // Present one request after a random gap; entered and left at a falling edge
   task automatic send_req(input aclr_pkg::req_type r, input bit typed,
                           input aclr_pkg::rsp_type want);
      int      gap;
      aclr_pkg::rsp_type pred;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_dimmer(r, pred);
      status_q.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic csr_put(input logic [1:0] idx, input logic [5:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         aclr_pkg::CSR_SUNRISE_HOUR:   alm_rise_h = val[4:0];
         aclr_pkg::CSR_SUNRISE_MINUTE: alm_rise_m = val;
         aclr_pkg::CSR_SUNSET_HOUR:    alm_set_h = val[4:0];
         aclr_pkg::CSR_SUNSET_MINUTE:  alm_set_m = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_alarms(input logic [5:0] rh, input logic [5:0] rm,
                               input logic [5:0] sh, input logic [5:0] sm);
      csr_put(aclr_pkg::CSR_SUNRISE_HOUR, rh);
      csr_put(aclr_pkg::CSR_SUNRISE_MINUTE, rm);
      csr_put(aclr_pkg::CSR_SUNSET_HOUR, sh);
      csr_put(aclr_pkg::CSR_SUNSET_MINUTE, sm);
      csr_write_en <= 1'b0;
   endtask

   // Let every outstanding status come back, plus pipeline margin
   task automatic drain();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Random run: mostly alarm approaches followed by tick bursts
   task automatic run_phase(input int quota);
      int         done;
      aclr_pkg::req_type r;
      aclr_pkg::rsp_type none;
      logic [5:0] tm;
      bit         to_rise;
      done = 0;
      none = '0;
      while (done < quota) begin
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               to_rise = 1'($urandom_range(0, 1));
               tm = to_rise ? alm_rise_m : alm_set_m;
               r = rand_fields();
               r.command = aclr_pkg::CMD_SET_TIME;
               r.set_hours = to_rise ? alm_rise_h : alm_set_h;
               if (tm != 6'd0 && $urandom_range(0, 1) == 0) begin
                  r.set_minutes = tm - 6'd1;
                  r.set_seconds = 6'($urandom_range(40, 59));
               end else begin
                  r.set_minutes = tm;
                  r.set_seconds = 6'($urandom_range(0, 59));
               end
               send_req(r, 1'b0, none);
               done++;
               repeat ($urandom_range(20, 120)) begin
                  r = rand_fields();
                  if (((ramp_ph == aclr_pkg::PHASE_RISE && duty == 8'd0) ||
                       (ramp_ph == aclr_pkg::PHASE_SET && duty == 8'd254)) &&
                      $urandom_range(0, 3) == 0) begin
                     // jump back into the alarm minute as the ramp finishes
                     r.command = aclr_pkg::CMD_SET_TIME;
                     r.set_hours = (ramp_ph == aclr_pkg::PHASE_RISE) ? alm_rise_h : alm_set_h;
                     r.set_minutes = (ramp_ph == aclr_pkg::PHASE_RISE) ? alm_rise_m
                                                                        : alm_set_m;
                     r.set_seconds = '0;
                  end else if ($urandom_range(0, 9) == 0) begin
                     r = noise_req();
                  end else begin
                     r.command = aclr_pkg::CMD_TICK;
                  end
                  send_req(r, 1'b0, none);
                  if (!is_ignored(r)) done++;
               end
            end
            6, 7: begin
               repeat ($urandom_range(1, 20)) begin
                  r = rand_fields();
                  r.command = aclr_pkg::CMD_TICK;
                  send_req(r, 1'b0, none);
                  done++;
               end
            end
            default: begin
               r = noise_req();
               send_req(r, 1'b0, none);
               if (!is_ignored(r)) done++;
            end
         endcase
      end
   endtask

   // Compare one status with the oldest prediction
   task automatic check_status(input aclr_pkg::rsp_type got);
      aclr_pkg::rsp_type want;
      if (status_q.size() == 0) begin
         $error("status with no request outstanding: %h", got);
         error_count++;
      end else begin
         want = status_q.pop_front();
         if (got.duty_value !== want.duty_value) begin
            $error("duty_value: expected %0d, actual %0d", want.duty_value, got.duty_value);
            error_count++;
         end
         if (got.pwm_running !== want.pwm_running) begin
            $error("pwm_running: expected %0d, actual %0d", want.pwm_running,
                   got.pwm_running);
            error_count++;
         end
         if (got.ramp_mode !== want.ramp_mode) begin
            $error("ramp_mode: expected %0d, actual %0d", want.ramp_mode, got.ramp_mode);
            error_count++;
         end
         if (got.clock_hours !== want.clock_hours) begin
            $error("clock_hours: expected %0d, actual %0d", want.clock_hours,
                   got.clock_hours);
            error_count++;
         end
         if (got.clock_minutes !== want.clock_minutes) begin
            $error("clock_minutes: expected %0d, actual %0d", want.clock_minutes,
                   got.clock_minutes);
            error_count++;
         end
         if (got.clock_seconds !== want.clock_seconds) begin
            $error("clock_seconds: expected %0d, actual %0d", want.clock_seconds,
                   got.clock_seconds);
            error_count++;
         end
      end
   endtask

   // Response side: sample at the rising edge, stall between responses
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_status(rsp_data);
         rsp_stall_left = draw_wait();
      end
   end

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Main sequence
   initial begin
      aclr_pkg::req_type r;
      aclr_pkg::rsp_type want;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = aclr_pkg::CSR_SUNRISE_HOUR;
      csr_wdata = '0;
      error_count = 0;
      cycle_count = 0;
      rsp_stall_left = 0;
      no_idle = 1'b0;
      tod_h = '0;
      tod_m = '0;
      tod_s = '0;
      ramp_ph = aclr_pkg::PHASE_IDLE;
      duty = '0;
      pwm_on = 1'b0;
      dwell_ct = '0;
      hold_ct = '0;
      alm_rise_h = aclr_pkg::SUNRISE_HOUR_RST;
      alm_rise_m = aclr_pkg::SUNRISE_MINUTE_RST;
      alm_set_h = aclr_pkg::SUNSET_HOUR_RST;
      alm_set_m = aclr_pkg::SUNSET_MINUTE_RST;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole dwell table before any ramp can read it
      want = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         r = rand_fields();
         r.command = aclr_pkg::CMD_LOAD_DELAY;
         r.table_index = 8'(i);
         r.table_delay = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(2, 3))
                                                     : 10'($urandom_range(0, 1));
         send_req(r, 1'b0, want);
      end

      // directed table
      for (int i = 0; i < 23; i++) begin
         r.command = 2'(dir_tab[i][0]);
         r.set_hours = 5'(dir_tab[i][1]);
         r.set_minutes = 6'(dir_tab[i][2]);
         r.set_seconds = 6'(dir_tab[i][3]);
         r.table_index = 8'(dir_tab[i][4]);
         r.table_delay = 10'(dir_tab[i][5]);
         want.duty_value = 8'(dir_tab[i][7]);
         want.pwm_running = 1'(dir_tab[i][8]);
         want.ramp_mode = 2'(dir_tab[i][9]);
         want.clock_hours = 5'(dir_tab[i][10]);
         want.clock_minutes = 6'(dir_tab[i][11]);
         want.clock_seconds = 6'(dir_tab[i][12]);
         send_req(r, dir_tab[i][6] != 0, want);
      end

      // random phases, each under its own alarm setting
      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: write_alarms(6'd0, 6'd0, 6'd23, 6'd59);
            1: write_alarms(6'd23, 6'd59, 6'd0, 6'd0);
            2: write_alarms(6'd7, 6'd30, 6'd7, 6'd30);
            3: write_alarms(6'd31, 6'd63, 6'd31, 6'd63);
            4: write_alarms(6'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                            6'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
            default: write_alarms(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                  6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         endcase
         run_phase(PHASE_QUOTA);
      end

      drain();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/aclr_pkg.sv
src/aclr_ram.sv
src/alarm_clock_led_ramp.sv
sim/tb_alarm_clock_led_ramp.sv
